FILE: rtl/dsefr_pkg.sv
`default_nettype none

package dsefr_pkg;

    // Field widths fixed by the interface.
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    // Default frame store capacity in bytes.
    localparam int FRAME_BYTES_DEF = 64;

    // Framing symbols.
    localparam logic [BYTE_W-1:0] SYM_STX = 8'h02;
    localparam logic [BYTE_W-1:0] SYM_ETX = 8'h03;
    localparam logic [BYTE_W-1:0] SYM_DLE = 8'h10;

    // Receive phase of the byte parser.
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_STX  = 2'd1,
        PH_DATA = 2'd2,
        PH_ESC  = 2'd3
    } rx_phase_t;

    // State of the frame emission sequencer.
    typedef enum logic [1:0] {
        EM_IDLE = 2'd0,
        EM_READ = 2'd1,
        EM_LOAD = 2'd2,
        EM_SHOW = 2'd3
    } emit_state_t;

    // Completed frame handed from the parser to the emitter.
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] length;
        logic             overflow;
    } frame_done_t;

endpackage

`default_nettype wire

FILE: rtl/dsefr_store.sv
`default_nettype none

module dsefr_store #(
    parameter int FRAME_BYTES = dsefr_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        wr_en,
    input  wire logic [((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1)-1:0] wr_addr,
    input  wire logic [dsefr_pkg::BYTE_W-1:0]                wr_data,
    input  wire logic                                        rd_en,
    input  wire logic [((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1)-1:0] rd_addr,
    output logic      [dsefr_pkg::BYTE_W-1:0]                rd_data
);

    logic [dsefr_pkg::BYTE_W-1:0] mem [FRAME_BYTES];
    logic [dsefr_pkg::BYTE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/dsefr_parse.sv
`default_nettype none

module dsefr_parse #(
    parameter int FRAME_BYTES = dsefr_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        accept,
    input  wire logic [dsefr_pkg::BYTE_W-1:0]                rx_byte,
    output logic                                             wr_en,
    output logic      [((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1)-1:0] wr_addr,
    output logic      [dsefr_pkg::BYTE_W-1:0]                wr_data,
    output dsefr_pkg::frame_done_t                           done
);

    localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [dsefr_pkg::LEN_W-1:0] CAPACITY = dsefr_pkg::LEN_W'(FRAME_BYTES);
    localparam logic [dsefr_pkg::LEN_W-1:0] ONE      = dsefr_pkg::LEN_W'(1);

    dsefr_pkg::rx_phase_t phase_reg, phase_next;
    logic [dsefr_pkg::LEN_W-1:0] count_reg, count_next;
    logic                        ovf_reg, ovf_next;

    logic is_dle, is_stx, is_etx;
    logic store_byte, clear_frame;

    assign is_dle = (rx_byte == dsefr_pkg::SYM_DLE);
    assign is_stx = (rx_byte == dsefr_pkg::SYM_STX);
    assign is_etx = (rx_byte == dsefr_pkg::SYM_ETX);

    // Phase transitions for each accepted byte.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            dsefr_pkg::PH_HUNT:
            begin
                if (accept && is_dle)
                begin
                    phase_next = dsefr_pkg::PH_STX;
                end
            end
            dsefr_pkg::PH_STX:
            begin
                if (accept)
                begin
                    phase_next = is_stx ? dsefr_pkg::PH_DATA : dsefr_pkg::PH_HUNT;
                end
            end
            dsefr_pkg::PH_DATA:
            begin
                if (accept && is_dle)
                begin
                    phase_next = dsefr_pkg::PH_ESC;
                end
            end
            dsefr_pkg::PH_ESC:
            begin
                if (accept)
                begin
                    phase_next = (is_dle || is_stx) ? dsefr_pkg::PH_DATA
                                                    : dsefr_pkg::PH_HUNT;
                end
            end
            default:
            begin
                phase_next = dsefr_pkg::PH_HUNT;
            end
        endcase
    end

    // Store writes, byte count and frame completion.
    always_comb
    begin
        store_byte  = accept &&
                      (((phase_reg == dsefr_pkg::PH_DATA) && !is_dle) ||
                       ((phase_reg == dsefr_pkg::PH_ESC) && is_dle));
        clear_frame = accept &&
                      (((phase_reg == dsefr_pkg::PH_STX) && is_stx) ||
                       ((phase_reg == dsefr_pkg::PH_ESC) && !is_dle));
        wr_en         = 1'b0;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        done.start    = accept && (phase_reg == dsefr_pkg::PH_ESC) && is_etx;
        done.length   = count_reg;
        done.overflow = ovf_reg;
        if (store_byte)
        begin
            if (count_reg < CAPACITY)
            begin
                wr_en      = 1'b1;
                count_next = count_reg + ONE;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (clear_frame)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    assign wr_addr = count_reg[ADDR_W-1:0];
    assign wr_data = rx_byte;

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dsefr_pkg::PH_HUNT;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dsefr_emit.sv
`default_nettype none

module dsefr_emit #(
    parameter int FRAME_BYTES = dsefr_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire dsefr_pkg::frame_done_t                      done,
    output logic                                             rd_en,
    output logic      [((FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1)-1:0] rd_addr,
    input  wire logic [dsefr_pkg::BYTE_W-1:0]                rd_data,
    output logic                                             busy,
    output logic                                             out_valid,
    input  wire logic                                        out_stall,
    output logic      [dsefr_pkg::BYTE_W-1:0]                out_byte,
    output logic                                             byte_valid,
    output logic      [dsefr_pkg::LEN_W-1:0]                 frame_length,
    output logic                                             overflowed,
    output logic                                             last
);

    localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [dsefr_pkg::LEN_W-1:0] ONE = dsefr_pkg::LEN_W'(1);

    dsefr_pkg::emit_state_t state_reg, state_next;
    logic [dsefr_pkg::LEN_W-1:0] len_reg;
    logic [dsefr_pkg::LEN_W-1:0] idx_reg;
    logic                        ovf_reg;
    logic [dsefr_pkg::BYTE_W-1:0] byte_reg;
    logic                        byte_valid_reg;
    logic                        last_reg;

    logic [dsefr_pkg::LEN_W-1:0] idx_inc;
    logic                        at_end;

    assign idx_inc = idx_reg + ONE;
    assign at_end  = (idx_inc >= len_reg);

    // Sequencer transitions: read (skipped for an empty frame), load the output register, present.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dsefr_pkg::EM_IDLE:
            begin
                if (done.start)
                begin
                    state_next = (done.length == '0) ? dsefr_pkg::EM_LOAD
                                                     : dsefr_pkg::EM_READ;
                end
            end
            dsefr_pkg::EM_READ:
            begin
                state_next = dsefr_pkg::EM_LOAD;
            end
            dsefr_pkg::EM_LOAD:
            begin
                state_next = dsefr_pkg::EM_SHOW;
            end
            dsefr_pkg::EM_SHOW:
            begin
                if (!out_stall)
                begin
                    state_next = at_end ? dsefr_pkg::EM_IDLE : dsefr_pkg::EM_READ;
                end
            end
            default:
            begin
                state_next = dsefr_pkg::EM_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        rd_en     = (state_reg == dsefr_pkg::EM_READ);
        busy      = (state_reg != dsefr_pkg::EM_IDLE);
        out_valid = (state_reg == dsefr_pkg::EM_SHOW);
    end

    assign rd_addr = idx_reg[ADDR_W-1:0];

    // Frame descriptor and byte index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsefr_pkg::EM_IDLE;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == dsefr_pkg::EM_IDLE) && done.start)
            begin
                len_reg <= done.length;
                ovf_reg <= done.overflow;
                idx_reg <= '0;
            end
            else if ((state_reg == dsefr_pkg::EM_SHOW) && !out_stall)
            begin
                idx_reg <= idx_inc;
            end
        end
    end

    // Output register, loaded from the store read data, or zero for an empty frame.
    always_ff @(posedge clk)
    begin
        if (state_reg == dsefr_pkg::EM_LOAD)
        begin
            byte_reg       <= (len_reg == '0) ? '0 : rd_data;
            byte_valid_reg <= (len_reg != '0);
            last_reg       <= at_end;
        end
    end

    assign out_byte     = byte_reg;
    assign byte_valid   = byte_valid_reg;
    assign frame_length = len_reg;
    assign overflowed   = ovf_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

FILE: rtl/dle_stx_etx_frame_receiver_top.sv
`default_nettype none

// DLE/STX/ETX frame receiver. Received bytes enter one per transfer on the
// input channel; outside a frame they are taken every cycle, and inside a
// frame each payload byte is written once into a frame store of FRAME_BYTES
// entries, also at one byte per cycle. A DLE escapes the next byte: DLE DLE
// stores one DLE, DLE STX restarts the frame, DLE ETX completes it, and any
// other escaped byte drops the frame without a result. Bytes beyond the store
// capacity are dropped and the frame is marked overflowed. On DLE ETX the
// input is stalled while the frame is emitted as a run of result transfers,
// one per stored byte, each carrying the frame length and the overflow mark,
// with last set on the final transfer; an empty frame gives one transfer
// with byte_valid low. Each result goes through a registered store read, an
// output register load and presentation, held while the output is stalled;
// the next byte is read only once it is taken. An empty frame skips the store
// read. Input resumes the cycle after the last result transfer.
module dle_stx_etx_frame_receiver_top #(
    parameter int FRAME_BYTES = dsefr_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [dsefr_pkg::BYTE_W-1:0]     rx_byte,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [dsefr_pkg::BYTE_W-1:0]     out_byte,
    output logic                                  byte_valid,
    output logic      [dsefr_pkg::LEN_W-1:0]      frame_length,
    output logic                                  overflowed,
    output logic                                  last
);

    localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    logic                         accept;
    logic                         busy;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [dsefr_pkg::BYTE_W-1:0] wr_data;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic [dsefr_pkg::BYTE_W-1:0] rd_data;
    dsefr_pkg::frame_done_t       done;

    // Input is held off while a frame is being emitted.
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    dsefr_parse #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .done    (done)
    );

    dsefr_store #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dsefr_emit #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .done         (done),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .busy         (busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .frame_length (frame_length),
        .overflowed   (overflowed),
        .last         (last)
    );

endmodule

`default_nettype wire
